>>> rtl/spq_pkg.sv
// Package for the sorted priority queue: sizes, codes and word types.
// Depends on nothing; every other source file uses it.
package spq_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned PRIO_BITS  = 4;
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned OUT_CNT_W  = 5;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e               op;
    logic [VALUE_BITS-1:0]  new_value;
    logic [PRIO_BITS-1:0]   new_prio;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]            command;
    logic [VALUE_BITS-1:0] value;
    logic [PRIO_BITS-1:0]  priority_req;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] front_value;
    logic [VALUE_BITS-1:0] back_value;
    logic [OUT_CNT_W-1:0]  item_count;
    logic                  is_empty;
    logic                  is_full;
    logic                  dropped;
  } out_word_t;

endpackage

>>> rtl/spq_in_if.sv
// Handshake channel for command words into the queue.
// Depends on spq_pkg for the word type.
interface spq_in_if;
  spq_pkg::in_word_t data;
  logic              valid;
  logic              ready;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/spq_out_if.sv
// Handshake channel for status words out of the queue.
// Depends on spq_pkg for the word type.
interface spq_out_if;
  spq_pkg::out_word_t data;
  logic               valid;
  logic               ready;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/spq_cell.sv
// One slot of the sorted queue: holds a value and its priority and shifts
// toward the tail on an insertion or toward the head on a pop. Uses spq_pkg.
module spq_cell (
  input  logic                          clk_i,
  input  spq_pkg::cell_ctl_t            ctl_i,
  input  logic                          occupied_i,
  input  logic                          left_keeps_i,
  input  logic [spq_pkg::VALUE_BITS-1:0] left_value_i,
  input  logic [spq_pkg::PRIO_BITS-1:0]  left_prio_i,
  input  logic [spq_pkg::VALUE_BITS-1:0] right_value_i,
  input  logic [spq_pkg::PRIO_BITS-1:0]  right_prio_i,
  output logic                          keeps_o,
  output logic [spq_pkg::VALUE_BITS-1:0] value_o,
  output logic [spq_pkg::PRIO_BITS-1:0]  prio_o
);
  import spq_pkg::*;

  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [PRIO_BITS-1:0]  prio_q, prio_d;

  // An occupied slot of strictly higher priority stays ahead of a new word.
  assign keeps_o = occupied_i && (prio_q > ctl_i.new_prio);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    unique case (ctl_i.op)
      CELL_PUSH: begin
        if (!keeps_o) begin
          if (left_keeps_i) begin
            value_d = ctl_i.new_value;
            prio_d  = ctl_i.new_prio;
          end else begin
            value_d = left_value_i;
            prio_d  = left_prio_i;
          end
        end
      end
      CELL_POP: begin
        value_d = right_value_i;
        prio_d  = right_prio_i;
      end
      CELL_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

>>> rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: a row of spq_cell slots, the
// fill count, the tail copy and the output register.
// Depends on spq_pkg, spq_in_if, spq_out_if and spq_cell.
//
//   Channel  Direction  Word fields
//   in_i     input      command, value, priority_req
//   out_o    output     front_value, back_value, item_count, is_empty,
//                       is_full, dropped
//
// A word is accepted each cycle while
// the status word register is empty or being taken. The status word of a
// command is valid in the cycle after it is accepted. Reset empties the
// queue and the status register; the slot contents need no reset. A stall
// on out_o holds both the status word and the queue contents.
module sorted_priority_queue_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);
  import spq_pkg::*;

  logic [CNT_W-1:0]      count_q, count_d;
  logic [VALUE_BITS-1:0] tail_q, tail_d;
  logic                  dropped_q, dropped_d;
  logic                  out_valid_q, out_valid_d;
  logic                  accept;
  logic                  full;
  cell_ctl_t             ctl;

  logic [CAPACITY-1:0]   occupied;
  logic [CAPACITY-1:0]   keeps;
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic [PRIO_BITS-1:0]  cell_prio [CAPACITY];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    ctl.op        = CELL_HOLD;
    ctl.new_value = in_i.data.value;
    ctl.new_prio  = in_i.data.priority_req;
    count_d       = count_q;
    tail_d        = tail_q;
    dropped_d     = dropped_q;
    out_valid_d   = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      dropped_d   = 1'b0;
      unique case (cmd_e'(in_i.data.command))
        CMD_PUSH: begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            ctl.op  = CELL_PUSH;
            count_d = count_q + CNT_W'(1);
            if (&(keeps | ~occupied)) begin
              tail_d = in_i.data.value;
            end
          end
        end
        CMD_POP: begin
          if (count_q != '0) begin
            ctl.op  = CELL_POP;
            count_d = count_q - CNT_W'(1);
          end
        end
        CMD_CLEAR: begin
          count_d = '0;
        end
        CMD_QUERY: begin
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  left_keeps;
    logic [VALUE_BITS-1:0] left_value;
    logic [PRIO_BITS-1:0]  left_prio;
    logic [VALUE_BITS-1:0] right_value;
    logic [PRIO_BITS-1:0]  right_prio;

    assign occupied[i] = (count_q > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_keeps = 1'b1;
      assign left_value = '0;
      assign left_prio  = '0;
    end else begin : g_body
      assign left_keeps = keeps[i-1];
      assign left_value = cell_value[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = '0;
      assign right_prio  = '0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .occupied_i    (occupied[i]),
      .left_keeps_i  (left_keeps),
      .left_value_i  (left_value),
      .left_prio_i   (left_prio),
      .right_value_i (right_value),
      .right_prio_i  (right_prio),
      .keeps_o       (keeps[i]),
      .value_o       (cell_value[i]),
      .prio_o        (cell_prio[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q <= tail_d;
  end

  // The status word is taken from the queue state, which only changes on
  // an accepted word and therefore holds while the output stalls.
  assign out_o.valid            = out_valid_q;
  assign out_o.data.front_value = (count_q == '0) ? '0 : cell_value[0];
  assign out_o.data.back_value  = (count_q == '0) ? '0 : tail_q;
  assign out_o.data.item_count  = OUT_CNT_W'(count_q);
  assign out_o.data.is_empty    = (count_q == '0);
  assign out_o.data.is_full     = full;
  assign out_o.data.dropped     = dropped_q;

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("Fill count exceeds the capacity.");

  a_drop_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && dropped_q |-> full)
    else $error("A refused push was reported while the queue was not full.");

  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.data.command == CMD_CLEAR) |=> (count_q == '0) && out_valid_q)
    else $error("Clear did not empty the queue.");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("Fill count changed without an accepted word.");

  a_head_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupied[1] |-> cell_prio[0] >= cell_prio[1])
    else $error("Head slot is out of priority order.");
`endif

endmodule

>>> dv/spq_checker.sv
// Checker for the sorted priority queue: watches both channels, keeps its own sorted store
// to predict every status word, and compares each returned word field by field.
// Depends on spq_pkg, spq_in_if and spq_out_if.
module spq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  spq_in_if           cmd_i,
  spq_out_if          stat_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned refused_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  logic [VALUE_BITS-1:0] slot_val  [CAPACITY];
  logic [PRIO_BITS-1:0]  slot_prio [CAPACITY];
  int unsigned           fill_level;
  out_word_t             status_q [$];
  int unsigned           mismatches = 0;
  int unsigned           words_checked = 0;
  int unsigned           pushes_refused = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = status_q.size();
  assign checked_o    = words_checked;
  assign refused_o    = pushes_refused;

  function automatic out_word_t predict_status(in_word_t w);
    out_word_t   s;
    int unsigned pos;
    int unsigned k;
    s = '0;
    case (cmd_e'(w.command))
      CMD_PUSH: begin
        if (fill_level >= CAPACITY) begin
          s.dropped = 1'b1;
          pushes_refused++;
        end else begin
          pos = 0;
          while (pos < fill_level && slot_prio[pos] > w.priority_req) pos++;
          for (k = fill_level; k > pos; k--) begin
            slot_val[k]  = slot_val[k-1];
            slot_prio[k] = slot_prio[k-1];
          end
          slot_val[pos]  = w.value;
          slot_prio[pos] = w.priority_req;
          fill_level++;
        end
      end
      CMD_POP: begin
        if (fill_level != 0) begin
          for (k = 1; k < fill_level; k++) begin
            slot_val[k-1]  = slot_val[k];
            slot_prio[k-1] = slot_prio[k];
          end
          fill_level--;
        end
      end
      CMD_CLEAR: fill_level = 0;
      default: ;
    endcase
    if (fill_level != 0) begin
      s.front_value = slot_val[0];
      s.back_value  = slot_val[fill_level-1];
    end
    s.item_count = OUT_CNT_W'(fill_level);
    s.is_empty   = (fill_level == 0);
    s.is_full    = (fill_level >= CAPACITY);
    return s;
  endfunction

  function automatic void report_mismatch(string what, out_word_t want, out_word_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR @%0t: %s", $realtime, what);
      $display("  expected front=%h back=%h count=%0d empty=%b full=%b dropped=%b",
               want.front_value, want.back_value, want.item_count, want.is_empty,
               want.is_full, want.dropped);
      $display("  actual   front=%h back=%h count=%0d empty=%b full=%b dropped=%b",
               got.front_value, got.back_value, got.item_count, got.is_empty,
               got.is_full, got.dropped);
    end
  endfunction

  function automatic void check_status(out_word_t got);
    out_word_t want;
    if (status_q.size() == 0) begin
      report_mismatch("status word with no command outstanding", '0, got);
      return;
    end
    want = status_q.pop_front();
    words_checked++;
    if (got.front_value !== want.front_value || got.back_value !== want.back_value ||
        got.item_count !== want.item_count || got.is_empty !== want.is_empty ||
        got.is_full !== want.is_full || got.dropped !== want.dropped) begin
      report_mismatch("status word differs", want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_level = 0;
      status_q.delete();
    end else begin
      if (stat_i.valid && stat_i.ready) check_status(stat_i.data);
      if (cmd_i.valid && cmd_i.ready) status_q.push_back(predict_status(cmd_i.data));
    end
  end

endmodule

>>> dv/tb.sv
// Top of the sorted priority queue testbench: clock, reset, command stimulus with random
// gaps, a stalling status receiver, a watchdog and the verdict.
// Depends on spq_pkg, spq_in_if, spq_out_if, spq_checker and sorted_priority_queue_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1100;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES    = 80;

  typedef enum int unsigned {
    PHASE_FILL  = 0,
    PHASE_DRAIN = 1,
    PHASE_MIXED = 2
  } phase_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        src_steady;
  int unsigned sent_total;
  int unsigned cmd_hist [4];
  int unsigned quiet_cycles = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned refused;

  spq_in_if  cmd_if ();
  spq_out_if stat_if ();

  sorted_priority_queue_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (stat_if)
  );

  spq_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_if),
    .stat_i       (stat_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .refused_o    (refused)
  );

  always #10 clk_i = ~clk_i;

  task automatic send_word(input cmd_e cmd, input logic [VALUE_BITS-1:0] val,
                           input logic [PRIO_BITS-1:0] prio);
    int unsigned gap;
    in_word_t    w;
    gap = src_steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    w.command      = cmd;
    w.value        = val;
    w.priority_req = prio;
    cmd_if.data  <= w;
    cmd_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    sent_total++;
    cmd_hist[int'(cmd)]++;
  endtask

  function automatic cmd_e pick_command(phase_e kind);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (kind)
      PHASE_FILL: begin
        if (r < 85) return CMD_PUSH;
        if (r < 95) return CMD_POP;
        return CMD_QUERY;
      end
      PHASE_DRAIN: begin
        if (r < 15) return CMD_PUSH;
        if (r < 85) return CMD_POP;
        if (r < 95) return CMD_QUERY;
        return CMD_CLEAR;
      end
      default: begin
        if (r < 45) return CMD_PUSH;
        if (r < 80) return CMD_POP;
        if (r < 92) return CMD_QUERY;
        return CMD_CLEAR;
      end
    endcase
  endfunction

  initial begin : status_sink
    int unsigned gap;
    int unsigned taken;
    logic        sink_steady;
    stat_if.ready <= 1'b0;
    taken       = 0;
    sink_steady = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken % 64 == 0) sink_steady = ($urandom_range(0, 3) == 0);
      gap = sink_steady ? 0 : $urandom_range(0, 9);
      if (taken == 200 || taken == 700) gap = HOLD_CYCLES;
      if (gap != 0) begin
        stat_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      stat_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!stat_if.valid) @(posedge clk_i);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (stat_if.valid && stat_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles.", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : command_source
    phase_e                kind;
    int unsigned           len;
    int unsigned           prio_mode;
    int unsigned           base;
    logic [PRIO_BITS-1:0]  prio;
    sent_total   = 0;
    cmd_hist     = '{default: 0};
    src_steady   = 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.data  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue, equal-priority ordering at head and tail, fill to full, refused push.
    send_word(CMD_QUERY, 16'h1234, 4'd3);
    send_word(CMD_POP, 16'hFFFF, 4'd15);
    send_word(CMD_PUSH, 16'hFFFF, 4'd0);
    send_word(CMD_PUSH, 16'h0000, 4'd15);
    send_word(CMD_PUSH, 16'hA5A5, 4'd15);
    send_word(CMD_PUSH, 16'h5A5A, 4'd0);
    send_word(CMD_QUERY, 16'h0000, 4'd0);
    send_word(CMD_POP, 16'h0000, 4'd0);
    repeat (13) send_word(CMD_PUSH, VALUE_BITS'($urandom), PRIO_BITS'($urandom_range(0, 15)));
    send_word(CMD_PUSH, 16'hBEEF, 4'd15);
    send_word(CMD_POP, 16'h0000, 4'd0);
    send_word(CMD_CLEAR, 16'hFFFF, 4'd15);
    send_word(CMD_QUERY, 16'h0000, 4'd0);

    while (sent_total < ITEM_TARGET) begin
      kind       = phase_e'($urandom_range(0, 2));
      len        = $urandom_range(12, 40);
      src_steady = ($urandom_range(0, 3) == 0);
      prio_mode  = $urandom_range(0, 2);
      base       = $urandom_range(0, 14);
      repeat (len) begin
        if (prio_mode == 0) prio = PRIO_BITS'($urandom_range(0, 15));
        else if (prio_mode == 1) prio = PRIO_BITS'(base + $urandom_range(0, 1));
        else prio = $urandom_range(0, 1) ? 4'd15 : 4'd0;
        send_word(pick_command(kind), VALUE_BITS'($urandom), prio);
      end
    end
    cmd_if.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d command words: %0d push, %0d pop, %0d clear, %0d query.",
             sent_total, cmd_hist[int'(CMD_PUSH)], cmd_hist[int'(CMD_POP)],
             cmd_hist[int'(CMD_CLEAR)], cmd_hist[int'(CMD_QUERY)]);
    $display("Compared %0d status words, %0d of them refused pushes on a full queue.",
             checked, refused);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/spq_pkg.sv
rtl/spq_in_if.sv
rtl/spq_out_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_unit.sv
dv/spq_checker.sv
dv/tb.sv
